@@ rtl/bir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Types, constants and the control store of the bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

	localparam int SrcBytesDef    = 65536;
	localparam int MaxChannelsDef = 4;
	localparam int MaxDim         = 256;

	localparam int RA_W   = 20;
	localparam int STEP_W = 4;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_STEP        = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_STEP        = 3'd3;
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

	typedef struct packed {
		logic        req_type;
		logic [15:0] load_address;
		logic [7:0]  load_value;
		logic [11:0] dest_row;
		logic [11:0] dest_col;
	} req_t;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] chan_d;
	} res_t;

	typedef enum logic [1:0] {
		NB_TL,
		NB_TR,
		NB_BL,
		NB_BR
	} nb_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MAP,
		OP_BASE,
		OP_WGT,
		OP_RD,
		OP_FIN,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		J_SEQ,
		J_GO,
		J_START,
		J_CHAN
	} jmp_t;

	typedef struct packed {
		op_t               op;
		nb_t               nb;
		jmp_t              jmp;
		logic [STEP_W-1:0] nxt;
	} ctl_t;

	localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] ST_MAP  = 4'd1;
	localparam logic [STEP_W-1:0] ST_BASE = 4'd2;
	localparam logic [STEP_W-1:0] ST_WGT  = 4'd3;
	localparam logic [STEP_W-1:0] ST_TL   = 4'd4;
	localparam logic [STEP_W-1:0] ST_TR   = 4'd5;
	localparam logic [STEP_W-1:0] ST_BL   = 4'd6;
	localparam logic [STEP_W-1:0] ST_BR   = 4'd7;
	localparam logic [STEP_W-1:0] ST_FIN  = 4'd8;
	localparam logic [STEP_W-1:0] ST_OUT  = 4'd9;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] s);
		ctl_t c;
		c = '{op: OP_NONE, nb: NB_TL, jmp: J_GO, nxt: ST_IDLE};
		unique case (s)
			ST_IDLE: c = '{op: OP_NONE, nb: NB_TL, jmp: J_START, nxt: ST_MAP};
			ST_MAP:  c = '{op: OP_MAP,  nb: NB_TL, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_BASE: c = '{op: OP_BASE, nb: NB_TL, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_WGT:  c = '{op: OP_WGT,  nb: NB_TL, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_TL:   c = '{op: OP_RD,   nb: NB_TL, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_TR:   c = '{op: OP_RD,   nb: NB_TR, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_BL:   c = '{op: OP_RD,   nb: NB_BL, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_BR:   c = '{op: OP_RD,   nb: NB_BR, jmp: J_SEQ,   nxt: ST_IDLE};
			ST_FIN:  c = '{op: OP_FIN,  nb: NB_TL, jmp: J_CHAN,  nxt: ST_TL};
			ST_OUT:  c = '{op: OP_OUT,  nb: NB_TL, jmp: J_GO,    nxt: ST_IDLE};
			default: c = '{op: OP_NONE, nb: NB_TL, jmp: J_GO,    nxt: ST_IDLE};
		endcase
		return c;
	endfunction

endpackage

@@ rtl/bir_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_store
// Source image byte store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bir_store #(
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bilinear_image_resampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// Source image store with bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// An item is transferred at a rising edge with start high and busy low.
// A load item (req_type 0) writes one source byte and gives no result; busy
// stays low, so loads go at one per cycle while no pixel item is running.
// A pixel item (req_type 1) raises busy while a microcoded sequencer runs:
// three set-up steps (position multiply, neighbour base, weights), then five
// steps per channel (four neighbour reads through the single read port of
// the store, then the channel result), then one closing step. The result
// sits on result for one cycle marked by done, registered from the closing
// step; busy is already low in that cycle, so the next request can follow
// at once.
// The receiver cannot stall: a result is taken in its done cycle.
// Reset sets the registers to width 1, height 1, steps 1.0, four channels,
// and leaves the byte store undefined until loaded.
// Configuration is written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module bilinear_image_resampler #(
	parameter int SRC_BYTES    = bir_pkg::SrcBytesDef,
	parameter int MAX_CHANNELS = bir_pkg::MaxChannelsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bir_pkg::req_t              req,
	output logic                       done,
	output bir_pkg::res_t              result,
	input  logic                       cfg_write,
	input  logic [bir_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bir_pkg::CFG_W-1:0]  cfg_data
);

	import bir_pkg::*;

	localparam int ADDR_W = $clog2(SRC_BYTES);

	logic [8:0]  src_width_q, src_height_q;
	logic [23:0] x_step_q, y_step_q;
	logic [2:0]  channel_count_q;

	logic [8:0]  w, h;
	logic [2:0]  cc;

	logic [STEP_W-1:0] step_q, step_d;
	ctl_t              ctl;
	logic              accept, more;

	logic [11:0] dest_row_q, dest_col_q;
	logic [35:0] px_q, py_q;
	logic [11:0] stride_q;
	logic [7:0]  fx_q, fy_q;
	logic        x_in_q, x1_in_q, y_in_q, y1_in_q;
	logic [19:0] row0_q;
	logic [10:0] colb_q;
	logic [16:0] wt_q [4];
	logic [3:0]  nv_q;
	logic [RA_W-1:0] base_q;
	logic [1:0]  k_q;

	logic [19:0] x_e, y_e;
	logic [20:0] x_e1, y_e1;
	logic        narrow;
	logic [7:0]  ifx_lo, ify_lo;
	logic [8:0]  ifx, ify, wfx, wfy;

	logic [RA_W-1:0] addr_rd;
	logic            rd_ok;
	logic [7:0]      rdata;
	logic            act_s1, rv_s1;
	nb_t             nb_s1;
	logic [24:0]     prod, acc_next, acc_q;

	res_t res_q;
	logic done_q;

	logic        st_we;
	logic [31:0] la32;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= 9'd1;
			src_height_q    <= 9'd1;
			x_step_q        <= 24'd65536;
			y_step_q        <= 24'd65536;
			channel_count_q <= 3'd4;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:     src_width_q     <= cfg_data[8:0];
				REG_SRC_HEIGHT:    src_height_q    <= cfg_data[8:0];
				REG_X_STEP:        x_step_q        <= cfg_data[23:0];
				REG_Y_STEP:        y_step_q        <= cfg_data[23:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w = src_width_q;
		if (src_width_q == 9'd0) w = 9'd1;
		else if (src_width_q > 9'(MaxDim)) w = 9'(MaxDim);
		h = src_height_q;
		if (src_height_q == 9'd0) h = 9'd1;
		else if (src_height_q > 9'(MaxDim)) h = 9'(MaxDim);
		cc = channel_count_q;
		if (channel_count_q == 3'd0) cc = 3'd1;
		else if (channel_count_q > 3'(MAX_CHANNELS)) cc = 3'(MAX_CHANNELS);
	end

	// sequencer
	assign ctl    = ucode(step_q);
	assign busy   = (step_q != ST_IDLE);
	assign accept = start && !busy;
	assign more   = ((3'(k_q) + 3'd1) < cc);

	always_comb begin
		step_d = step_q;
		unique case (ctl.jmp)
			J_SEQ:   step_d = step_q + 4'd1;
			J_GO:    step_d = ctl.nxt;
			J_START: step_d = (accept && req.req_type) ? ctl.nxt : step_q;
			J_CHAN:  step_d = more ? ctl.nxt : step_q + 4'd1;
			default: step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			done_q <= 1'b0;
			act_s1 <= 1'b0;
		end else begin
			step_q <= step_d;
			done_q <= (ctl.op == OP_OUT);
			act_s1 <= (ctl.op == OP_RD);
		end
	end

	// loads
	assign la32  = 32'(req.load_address);
	assign st_we = accept && !req.req_type && (la32 < 32'(SRC_BYTES));

	// datapath
	assign narrow = (w == 9'd1) || (h == 9'd1);
	assign x_e    = (w == 9'd1) ? 20'd0 : px_q[35:16];
	assign y_e    = (h == 9'd1) ? 20'd0 : py_q[35:16];
	assign x_e1   = 21'(x_e) + 21'd1;
	assign y_e1   = 21'(y_e) + 21'd1;

	assign ifx    = 9'(MaxDim) - 9'(fx_q);
	assign ify    = 9'(MaxDim) - 9'(fy_q);
	assign wfx    = 9'(fx_q);
	assign wfy    = 9'(fy_q);
	assign ifx_lo = narrow ? 8'd0 : px_q[15:8];
	assign ify_lo = narrow ? 8'd0 : py_q[15:8];

	always_comb begin
		addr_rd = base_q;
		if (ctl.nb == NB_TR || ctl.nb == NB_BR) addr_rd = addr_rd + RA_W'(cc);
		if (ctl.nb == NB_BL || ctl.nb == NB_BR) addr_rd = addr_rd + RA_W'(stride_q);
	end

	assign rd_ok = nv_q[ctl.nb] && (32'(addr_rd) < 32'(SRC_BYTES));

	assign prod     = rv_s1 ? (25'(wt_q[nb_s1]) * 25'(rdata)) : 25'd0;
	assign acc_next = ((nb_s1 == NB_TL) ? 25'd0 : acc_q) + prod;

	always_ff @(posedge clk) begin
		if (accept && req.req_type) begin
			dest_row_q <= req.dest_row;
			dest_col_q <= req.dest_col;
		end
		unique case (ctl.op)
			OP_MAP: begin
				px_q     <= 36'(dest_col_q) * 36'(x_step_q);
				py_q     <= 36'(dest_row_q) * 36'(y_step_q);
				stride_q <= 12'(w) * 12'(cc);
			end
			OP_BASE: begin
				fx_q    <= ifx_lo;
				fy_q    <= ify_lo;
				x_in_q  <= (x_e < 20'(w));
				x1_in_q <= (x_e1 < 21'(w));
				y_in_q  <= (y_e < 20'(h));
				y1_in_q <= (y_e1 < 21'(h));
				row0_q  <= 20'(y_e[7:0]) * 20'(stride_q);
				colb_q  <= 11'(x_e[7:0]) * 11'(cc);
			end
			OP_WGT: begin
				wt_q[NB_TL] <= 17'(18'(ifx) * 18'(ify));
				wt_q[NB_TR] <= 17'(18'(wfx) * 18'(ify));
				wt_q[NB_BL] <= 17'(18'(ifx) * 18'(wfy));
				wt_q[NB_BR] <= 17'(18'(wfx) * 18'(wfy));
				nv_q[NB_TL] <= x_in_q  && y_in_q;
				nv_q[NB_TR] <= x1_in_q && y_in_q;
				nv_q[NB_BL] <= x_in_q  && y1_in_q;
				nv_q[NB_BR] <= x1_in_q && y1_in_q;
				base_q      <= row0_q + RA_W'(colb_q);
				k_q         <= 2'd0;
			end
			OP_FIN: begin
				if (more) begin
					k_q    <= k_q + 2'd1;
					base_q <= base_q + RA_W'(1);
				end
			end
			default: ;
		endcase
		if (ctl.op == OP_RD) begin
			nb_s1 <= ctl.nb;
			rv_s1 <= rd_ok;
		end
		if (act_s1) begin
			acc_q <= acc_next;
		end
	end

	// result
	always_ff @(posedge clk) begin
		if (accept && req.req_type) begin
			res_q <= '0;
		end else if (ctl.op == OP_FIN) begin
			unique case (k_q)
				2'd0: res_q.chan_a <= acc_next[23:16];
				2'd1: res_q.chan_b <= acc_next[23:16];
				2'd2: res_q.chan_c <= acc_next[23:16];
				2'd3: res_q.chan_d <= acc_next[23:16];
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	bir_store #(
		.DEPTH (SRC_BYTES)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (la32[ADDR_W-1:0]),
		.wdata (req.load_value),
		.raddr (addr_rd[ADDR_W-1:0]),
		.rdata (rdata)
	);

endmodule
